// ===== src/mct_pkg.sv =====
`default_nettype none
package mct_pkg;

  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int BUTTON_WIDTH  = 10;
  localparam int BUTTON_HEIGHT = 3;
  localparam int BUTTON_GAP    = 2;

  // Sub-cell steps: 4 per column, 8 per row
  localparam int X_SHIFT = 2;
  localparam int Y_SHIFT = 3;

  localparam int X_LIMIT = (SCREEN_COLS - 1) << X_SHIFT;
  localparam int Y_LIMIT = (SCREEN_ROWS - 1) << Y_SHIFT;
  localparam int FINE_X_W = $clog2(X_LIMIT + 1);
  localparam int FINE_Y_W = $clog2(Y_LIMIT + 1);
  localparam int FINE_MAX_W = (FINE_X_W > FINE_Y_W) ?
                              ((FINE_X_W > 8) ? FINE_X_W : 8) :
                              ((FINE_Y_W > 8) ? FINE_Y_W : 8);
  localparam int SUM_W = FINE_MAX_W + 2;

  localparam logic [FINE_X_W-1:0] FINE_X_RESET =
    FINE_X_W'((SCREEN_COLS / 2) << X_SHIFT);
  localparam logic [FINE_Y_W-1:0] FINE_Y_RESET =
    FINE_Y_W'((SCREEN_ROWS / 2) << Y_SHIFT);

  localparam logic [7:0] BTN_W8      = 8'(BUTTON_WIDTH);
  localparam logic [7:0] BTN_H8      = 8'(BUTTON_HEIGHT);
  localparam logic [7:0] BTN_PITCH8  = 8'(BUTTON_WIDTH + BUTTON_GAP);

  localparam int LEFT_BIT = 0;

  // Configuration register indexes
  localparam logic [2:0] CFG_BUTTON_X    = 3'd0;
  localparam logic [2:0] CFG_BUTTON_Y    = 3'd1;
  localparam logic [2:0] CFG_LIST_X      = 3'd2;
  localparam logic [2:0] CFG_LIST_Y      = 3'd3;
  localparam logic [2:0] CFG_LIST_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_LIST_HEIGHT = 3'd5;

  typedef enum logic [2:0] {
    REGION_NONE = 3'd0,
    REGION_BTN0 = 3'd1,
    REGION_BTN1 = 3'd2,
    REGION_BTN2 = 3'd3,
    REGION_BTN3 = 3'd4,
    REGION_LIST = 3'd5
  } region_t;

  typedef struct packed {
    logic [7:0] counter_x;
    logic [7:0] counter_y;
    logic [7:0] button_byte;
  } sample_t;

  typedef struct packed {
    logic [7:0] button_x;
    logic [7:0] button_y;
    logic [7:0] list_x;
    logic [7:0] list_y;
    logic [7:0] list_width;
    logic [7:0] list_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       click;
    logic [7:0] wheel;
    logic       test;
  } track_t;

  typedef struct packed {
    region_t    region;
    logic [7:0] list_row;
  } hit_t;

  // lo <= v < (lo + len) mod 256, all on 8 bits
  function automatic logic in_span(input logic [7:0] v, input logic [7:0] lo,
                                   input logic [7:0] len);
    logic [7:0] hi;
    hi = lo + len;
    return (v >= lo) && (v < hi);
  endfunction

endpackage
`default_nettype wire

// ===== src/mct_ifs.sv =====
`default_nettype none
interface mct_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] counter_x;
  logic [7:0] counter_y;
  logic [7:0] button_byte;

  modport source (output valid, counter_x, counter_y, button_byte, input ready);
  modport sink   (input valid, counter_x, counter_y, button_byte, output ready);
endinterface

interface mct_result_if;
  logic              valid;
  logic              ready;
  logic [6:0]        cursor_col;
  logic [4:0]        cursor_row;
  logic              left_click;
  logic signed [7:0] wheel_step;
  logic [2:0]        hit_region;
  logic [7:0]        list_row;

  modport source (output valid, cursor_col, cursor_row, left_click, wheel_step,
                  hit_region, list_row, input ready);
  modport sink   (input valid, cursor_col, cursor_row, left_click, wheel_step,
                  hit_region, list_row, output ready);
endinterface
`default_nettype wire

// ===== src/mouse_cursor_tracker_hit_test_unit.sv =====
// Mouse cursor tracker with text-cell hit test.
// A sample passes from the input register to the result register; a stalled result holds it in the input register.
// Throughput: one sample per cycle while the result side takes results; the tracking state (fine position, held
// counters, buttons) is updated as the sample leaves the input register.
// Reset clears the pipeline and the configuration registers and sets the tracking state to its start (cursor centred);
// the first sample after reset primes the held counters and buttons and moves nothing.
`default_nettype none
module mouse_cursor_tracker_hit_test_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_index,
  input  wire logic [7:0] wr_data,
  mct_sample_if.sink      samples,
  mct_result_if.source    results
);

  mct_pkg::cfg_t    cfg;
  mct_pkg::sample_t smp;
  logic             smp_valid;
  logic             res_valid;
  logic             adv;
  logic [7:0]       held_list_row;
  logic [7:0]       held_list_row_next;
  mct_pkg::track_t  trk;
  mct_pkg::hit_t    hit;
  mct_pkg::region_t region;

  assign adv = smp_valid && (!res_valid || results.ready);
  assign samples.ready = !smp_valid || adv;
  assign results.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        mct_pkg::CFG_BUTTON_X:    cfg.button_x    <= wr_data;
        mct_pkg::CFG_BUTTON_Y:    cfg.button_y    <= wr_data;
        mct_pkg::CFG_LIST_X:      cfg.list_x      <= wr_data;
        mct_pkg::CFG_LIST_Y:      cfg.list_y      <= wr_data;
        mct_pkg::CFG_LIST_WIDTH:  cfg.list_width  <= wr_data;
        mct_pkg::CFG_LIST_HEIGHT: cfg.list_height <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      smp_valid <= 1'b1;
    end else if (adv) begin
      smp_valid <= 1'b0;
    end
    if (samples.valid && samples.ready) begin
      smp.counter_x   <= samples.counter_x;
      smp.counter_y   <= samples.counter_y;
      smp.button_byte <= samples.button_byte;
    end
  end

  mct_track u_track (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .smp (smp),
    .trk (trk)
  );

  mct_hit u_hit (
    .cfg (cfg),
    .col (trk.col),
    .row (trk.row),
    .hit (hit)
  );

  always_comb begin
    region = trk.test ? hit.region : mct_pkg::REGION_NONE;
    held_list_row_next = (region == mct_pkg::REGION_LIST) ? hit.list_row : held_list_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_list_row <= 8'd0;
    end else if (adv) begin
      held_list_row <= held_list_row_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (adv) begin
      results.cursor_col <= 7'(trk.col);
      results.cursor_row <= 5'(trk.row);
      results.left_click <= trk.click;
      results.wheel_step <= $signed(trk.wheel);
      results.hit_region <= region;
      results.list_row   <= held_list_row_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mct_track.sv =====
`default_nettype none
module mct_track (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire mct_pkg::sample_t smp,
  output mct_pkg::track_t       trk
);

  logic                          primed;
  logic [7:0]                    last_x;
  logic [7:0]                    last_y;
  logic                          last_left;
  logic [3:0]                    last_nib;
  logic [mct_pkg::FINE_X_W-1:0]  fine_x;
  logic [mct_pkg::FINE_Y_W-1:0]  fine_y;
  logic [mct_pkg::FINE_X_W-1:0]  fine_x_next;
  logic [mct_pkg::FINE_Y_W-1:0]  fine_y_next;

  logic signed [7:0]               dx;
  logic signed [7:0]               dy;
  logic signed [mct_pkg::SUM_W-1:0] sum_x;
  logic signed [mct_pkg::SUM_W-1:0] sum_y;
  logic signed [mct_pkg::SUM_W-1:0] lim_x;
  logic signed [mct_pkg::SUM_W-1:0] lim_y;
  logic                            moved;
  logic                            click;

  always_comb begin
    dx = $signed(smp.counter_x - last_x);
    dy = $signed(last_y - smp.counter_y);
    moved = (dx != 8'sd0) || (dy != 8'sd0);
    lim_x = $signed(mct_pkg::SUM_W'(mct_pkg::X_LIMIT));
    lim_y = $signed(mct_pkg::SUM_W'(mct_pkg::Y_LIMIT));
    sum_x = $signed(mct_pkg::SUM_W'(fine_x)) + mct_pkg::SUM_W'(dx);
    sum_y = $signed(mct_pkg::SUM_W'(fine_y)) + mct_pkg::SUM_W'(dy);

    // saturate at zero and at the first fine position of the last cell
    fine_x_next = fine_x;
    fine_y_next = fine_y;
    if (primed) begin
      if (sum_x < 0) begin
        fine_x_next = '0;
      end else if (sum_x > lim_x) begin
        fine_x_next = mct_pkg::FINE_X_W'(mct_pkg::X_LIMIT);
      end else begin
        fine_x_next = mct_pkg::FINE_X_W'(sum_x);
      end
      if (sum_y < 0) begin
        fine_y_next = '0;
      end else if (sum_y > lim_y) begin
        fine_y_next = mct_pkg::FINE_Y_W'(mct_pkg::Y_LIMIT);
      end else begin
        fine_y_next = mct_pkg::FINE_Y_W'(sum_y);
      end
    end

    click = primed && last_left && !smp.button_byte[mct_pkg::LEFT_BIT];

    trk.col   = 8'(fine_x_next >> mct_pkg::X_SHIFT);
    trk.row   = 8'(fine_y_next >> mct_pkg::Y_SHIFT);
    trk.click = click;
    trk.wheel = primed ? {smp.button_byte[7:4] - last_nib, 4'b0000} : 8'd0;
    trk.test  = primed && (moved || click);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      last_x    <= 8'd0;
      last_y    <= 8'd0;
      last_left <= 1'b1;
      last_nib  <= 4'd0;
      fine_x    <= mct_pkg::FINE_X_RESET;
      fine_y    <= mct_pkg::FINE_Y_RESET;
    end else if (adv) begin
      primed    <= 1'b1;
      last_x    <= smp.counter_x;
      last_y    <= smp.counter_y;
      last_left <= smp.button_byte[mct_pkg::LEFT_BIT];
      last_nib  <= smp.button_byte[7:4];
      fine_x    <= fine_x_next;
      fine_y    <= fine_y_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/mct_hit.sv =====
`default_nettype none
module mct_hit (
  input  wire mct_pkg::cfg_t cfg,
  input  wire logic [7:0]    col,
  input  wire logic [7:0]    row,
  output mct_pkg::hit_t      hit
);

  logic [7:0] x1;
  logic [7:0] y1;
  logic       in_x0;
  logic       in_x1;
  logic       in_y0;
  logic       in_y1;
  logic       in_list;

  always_comb begin
    x1 = cfg.button_x + mct_pkg::BTN_PITCH8;
    y1 = cfg.button_y + mct_pkg::BTN_H8;
    in_x0 = mct_pkg::in_span(col, cfg.button_x, mct_pkg::BTN_W8);
    in_x1 = mct_pkg::in_span(col, x1, mct_pkg::BTN_W8);
    in_y0 = mct_pkg::in_span(row, cfg.button_y, mct_pkg::BTN_H8);
    in_y1 = mct_pkg::in_span(row, y1, mct_pkg::BTN_H8);
    in_list = mct_pkg::in_span(col, cfg.list_x, cfg.list_width) &&
              mct_pkg::in_span(row, cfg.list_y, cfg.list_height);

    hit.list_row = row - cfg.list_y;
    // buttons win over the list, lower button number first
    if (in_x0 && in_y0) begin
      hit.region = mct_pkg::REGION_BTN0;
    end else if (in_x1 && in_y0) begin
      hit.region = mct_pkg::REGION_BTN1;
    end else if (in_x0 && in_y1) begin
      hit.region = mct_pkg::REGION_BTN2;
    end else if (in_x1 && in_y1) begin
      hit.region = mct_pkg::REGION_BTN3;
    end else if (in_list) begin
      hit.region = mct_pkg::REGION_LIST;
    end else begin
      hit.region = mct_pkg::REGION_NONE;
    end
  end

endmodule
`default_nettype wire

// ===== tb/mouse_cursor_tracker_hit_test_unit_tb.sv =====
`timescale 1ns / 1ps

module mouse_cursor_tracker_hit_test_unit_tb;

  localparam int X_STEPS = 4;
  localparam int Y_STEPS = 8;
  localparam logic [7:0] LEFT_MASK = 8'h01;
  localparam logic [7:0] WHEEL_FIELD = 8'hf0;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int RANDOM_PHASES = 6;

  typedef struct {
    logic [6:0] col;
    logic [4:0] row;
    logic       click;
    logic [7:0] wheel;
    logic [2:0] region;
    logic [7:0] list_row;
  } cursor_cell_t;

  class cursor_track_board;
    logic [7:0] button_x, button_y, list_x, list_y, list_width, list_height;
    bit         primed;
    logic [7:0] last_x, last_y, last_buttons, last_wheel;
    int         fine_x, fine_y;
    logic [7:0] held_row;
    cursor_cell_t expected_cells[$];
    int         faults;

    function void reset();
      button_x = '0; button_y = '0; list_x = '0;
      list_y = '0; list_width = '0; list_height = '0;
      primed = 1'b0;
      last_x = '0;
      last_y = '0;
      last_buttons = 8'hff;
      last_wheel = '0;
      fine_x = (mct_pkg::SCREEN_COLS / 2) * X_STEPS;
      fine_y = (mct_pkg::SCREEN_ROWS / 2) * Y_STEPS;
      held_row = '0;
      expected_cells.delete();
    endfunction

    function void set_reg(input logic [2:0] index, input logic [7:0] value);
      case (index)
        mct_pkg::CFG_BUTTON_X:    button_x = value;
        mct_pkg::CFG_BUTTON_Y:    button_y = value;
        mct_pkg::CFG_LIST_X:      list_x = value;
        mct_pkg::CFG_LIST_Y:      list_y = value;
        mct_pkg::CFG_LIST_WIDTH:  list_width = value;
        mct_pkg::CFG_LIST_HEIGHT: list_height = value;
        default: ;
      endcase
    endfunction

    // lo <= v < hi with the upper bound wrapped to 8 bits
    function bit spans(input logic [7:0] v, input logic [7:0] lo, input logic [7:0] len);
      logic [7:0] hi;
      hi = lo + len;
      return (v >= lo) && (v < hi);
    endfunction

    function mct_pkg::region_t locate(input logic [7:0] col, input logic [7:0] row);
      logic [7:0] x1, y1;
      logic [7:0] bw, bh;
      bw = 8'(mct_pkg::BUTTON_WIDTH);
      bh = 8'(mct_pkg::BUTTON_HEIGHT);
      x1 = button_x + 8'(mct_pkg::BUTTON_WIDTH + mct_pkg::BUTTON_GAP);
      y1 = button_y + bh;
      if (spans(col, button_x, bw) && spans(row, button_y, bh)) return mct_pkg::REGION_BTN0;
      if (spans(col, x1, bw) && spans(row, button_y, bh)) return mct_pkg::REGION_BTN1;
      if (spans(col, button_x, bw) && spans(row, y1, bh)) return mct_pkg::REGION_BTN2;
      if (spans(col, x1, bw) && spans(row, y1, bh)) return mct_pkg::REGION_BTN3;
      if (spans(col, list_x, list_width) && spans(row, list_y, list_height)) begin
        held_row = row - list_y;
        return mct_pkg::REGION_LIST;
      end
      return mct_pkg::REGION_NONE;
    endfunction

    function void take_sample(input logic [7:0] nx, input logic [7:0] ny,
                              input logic [7:0] nb);
      cursor_cell_t c;
      logic [7:0] nw, dxb, dyb;
      int dx, dy;
      bit moved;
      c.click = 1'b0;
      c.wheel = '0;
      c.region = mct_pkg::REGION_NONE;
      nw = nb & WHEEL_FIELD;
      if (!primed) begin
        last_x = nx;
        last_y = ny;
        last_buttons = nb;
        last_wheel = nw;
        primed = 1'b1;
      end else begin
        dxb = nx - last_x;
        dyb = last_y - ny;
        dx = $signed(dxb);
        dy = $signed(dyb);
        moved = (dx != 0) || (dy != 0);
        last_x = nx;
        last_y = ny;
        if (moved) begin
          fine_x = fine_x + dx;
          if (fine_x < 0) fine_x = 0;
          if (fine_x > mct_pkg::X_LIMIT) fine_x = mct_pkg::X_LIMIT;
          fine_y = fine_y + dy;
          if (fine_y < 0) fine_y = 0;
          if (fine_y > mct_pkg::Y_LIMIT) fine_y = mct_pkg::Y_LIMIT;
        end
        c.click = ((last_buttons & LEFT_MASK) != 0) && ((nb & LEFT_MASK) == 0);
        last_buttons = nb;
        if (nw != last_wheel) begin
          c.wheel = nw - last_wheel;
          last_wheel = nw;
        end
        if (moved || c.click)
          c.region = locate(8'(fine_x / X_STEPS), 8'(fine_y / Y_STEPS));
      end
      c.col = 7'(fine_x / X_STEPS);
      c.row = 5'(fine_y / Y_STEPS);
      c.list_row = held_row;
      expected_cells.push_back(c);
    endfunction

    function void check_field(input string name, input int want, input int got);
      if (want != got) begin
        faults++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_cell(input cursor_cell_t got);
      cursor_cell_t want;
      if (expected_cells.size() == 0) begin
        faults++;
        $display("%0t: result with nothing expected: expected none, actual col %0d row %0d",
                 $time, got.col, got.row);
        return;
      end
      want = expected_cells.pop_front();
      check_field("cursor_col", want.col, got.col);
      check_field("cursor_row", want.row, got.row);
      check_field("left_click", want.click, got.click);
      check_field("wheel_step", $signed(want.wheel), $signed(got.wheel));
      check_field("hit_region", want.region, got.region);
      check_field("list_row", want.list_row, got.list_row);
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en;
  logic [2:0] wr_index;
  logic [7:0] wr_data;

  mct_sample_if sample_ch ();
  mct_result_if result_ch ();

  mouse_cursor_tracker_hit_test_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .samples  (sample_ch),
    .results  (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cursor_track_board board;
  logic [7:0] cur_x, cur_y, cur_b;
  int  n_sent;
  int  burst_left;
  int  idle_cycles;
  bit  hold_req;

  // Receiver: ready pattern in segments, plus a long hold-off on request
  initial begin
    int mode, len;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          result_ch.ready = 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          @(negedge clk);
          case (mode)
            0: result_ch.ready = 1'b1;
            1: result_ch.ready = $urandom_range(0, 1);
            2: result_ch.ready = ($urandom_range(0, 4) != 0);
            default: result_ch.ready = (i % 4) == 3;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cursor_cell_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.col = result_ch.cursor_col;
      got.row = result_ch.cursor_row;
      got.click = result_ch.left_click;
      got.wheel = result_ch.wheel_step;
      got.region = result_ch.hit_region;
      got.list_row = result_ch.list_row;
      board.check_cell(got);
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("mouse_cursor_tracker_hit_test_unit verification failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic send_item(input logic [7:0] x, input logic [7:0] y, input logic [7:0] b);
    int gap;
    @(negedge clk);
    sample_ch.valid = 1'b1;
    sample_ch.counter_x = x;
    sample_ch.counter_y = y;
    sample_ch.button_byte = b;
    do @(posedge clk); while (!sample_ch.ready);
    board.take_sample(x, y, b);
    cur_x = x;
    cur_y = y;
    cur_b = b;
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // no gap a third of the time, so long back-to-back stretches occur
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        sample_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic load_config(input logic [7:0] bx, input logic [7:0] by,
                             input logic [7:0] lx, input logic [7:0] ly,
                             input logic [7:0] lw, input logic [7:0] lh);
    logic [2:0] idx[6];
    logic [7:0] vals[6];
    idx = '{mct_pkg::CFG_BUTTON_X, mct_pkg::CFG_BUTTON_Y,
            mct_pkg::CFG_LIST_X, mct_pkg::CFG_LIST_Y,
            mct_pkg::CFG_LIST_WIDTH, mct_pkg::CFG_LIST_HEIGHT};
    vals = '{bx, by, lx, ly, lw, lh};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      wr_en = 1'b1;
      wr_index = idx[i];
      wr_data = vals[i];
      @(posedge clk);
      board.set_reg(idx[i], vals[i]);
    end
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Walk the cursor to a cell with the left button up, -128 to 127 fine steps per axis per transfer
  task automatic steer_to(input int col, input int row);
    int fx, fy, mx, my;
    fx = col * X_STEPS + $urandom_range(0, X_STEPS - 1);
    fy = row * Y_STEPS + $urandom_range(0, Y_STEPS - 1);
    for (int n = 0; n < 6; n++) begin
      mx = fx - board.fine_x;
      my = fy - board.fine_y;
      if (mx == 0 && my == 0) break;
      if (mx > 127) mx = 127;
      if (mx < -128) mx = -128;
      if (my > 127) my = 127;
      if (my < -128) my = -128;
      send_item(cur_x + 8'(mx), cur_y - 8'(my), cur_b | LEFT_MASK);
    end
  endtask

  task automatic visit_region();
    int col, row;
    case ($urandom_range(0, 2))
      0: begin
        col = (board.button_x +
               $urandom_range(0, 2 * mct_pkg::BUTTON_WIDTH + mct_pkg::BUTTON_GAP - 1)) % 256;
        row = (board.button_y + $urandom_range(0, 2 * mct_pkg::BUTTON_HEIGHT - 1)) % 256;
      end
      1: begin
        col = (board.list_x +
               $urandom_range(0, (board.list_width == 0) ? 0 : board.list_width - 1)) % 256;
        row = (board.list_y +
               $urandom_range(0, (board.list_height == 0) ? 0 : board.list_height - 1)) % 256;
      end
      default: begin
        col = $urandom_range(0, mct_pkg::SCREEN_COLS - 1);
        row = $urandom_range(0, mct_pkg::SCREEN_ROWS - 1);
      end
    endcase
    if (col >= mct_pkg::SCREEN_COLS) col = $urandom_range(0, mct_pkg::SCREEN_COLS - 1);
    if (row >= mct_pkg::SCREEN_ROWS) row = $urandom_range(0, mct_pkg::SCREEN_ROWS - 1);
    steer_to(col, row);
    if ($urandom_range(0, 1)) send_item(cur_x, cur_y, cur_b & ~LEFT_MASK);
  endtask

  task automatic random_item();
    int kind;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    b = cur_b;
    if ($urandom_range(0, 3) == 0) b[7:4] = 4'($urandom);
    b[3:1] = 3'($urandom);
    if ($urandom_range(0, 2) == 0) b[0] = ~b[0];
    if (kind < 35)
      send_item(cur_x + 8'($urandom_range(0, 16)) - 8'd8,
                cur_y + 8'($urandom_range(0, 16)) - 8'd8, b);
    else if (kind < 50)
      send_item(cur_x + 8'($urandom), cur_y + 8'($urandom), b);
    else if (kind < 60)
      send_item(cur_x, cur_y, b);
    else if (kind < 70)
      send_item(8'($urandom), 8'($urandom), 8'($urandom));
    else
      visit_region();
  endtask

  initial begin
    int stop_at;
    board = new();
    board.reset();
    wr_en = 1'b0;
    wr_index = mct_pkg::CFG_BUTTON_X;
    wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.counter_x = '0;
    sample_ch.counter_y = '0;
    sample_ch.button_byte = '0;
    cur_x = '0;
    cur_y = '0;
    cur_b = 8'hff;
    n_sent = 0;
    burst_left = 1;
    idle_cycles = 0;
    hold_req = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    load_config(8'd20, 8'd4, 8'd40, 8'd12, 8'd30, 8'd10);
    send_item(8'h80, 8'h80, 8'hff);          // priming sample
    send_item(8'h80, 8'h80, 8'hff);          // no motion, no click
    send_item(8'h80, 8'h80, 8'hfe);          // click in place
    send_item(8'h80, 8'h80, 8'h0e);          // wheel wraps upward
    send_item(8'h80, 8'h80, 8'hf1);          // wheel wraps downward, release
    repeat (2) send_item(cur_x + 8'd127, cur_y, cur_b);   // clamp right
    repeat (3) send_item(cur_x + 8'h80, cur_y, cur_b);    // clamp left
    send_item(cur_x, cur_y - 8'd127, cur_b);              // clamp bottom
    repeat (2) send_item(cur_x, cur_y + 8'h80, cur_b);    // clamp top
    steer_to(21, 5);
    steer_to(33, 5);
    steer_to(21, 8);
    steer_to(33, 8);
    steer_to(50, 15);
    send_item(cur_x, cur_y, cur_b & ~LEFT_MASK);
    steer_to(mct_pkg::SCREEN_COLS - 1, mct_pkg::SCREEN_ROWS - 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        1: load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        2: load_config(8'($urandom_range(0, 79)), 8'($urandom_range(0, 24)),
                       8'($urandom_range(0, 79)), 8'($urandom_range(0, 24)),
                       8'($urandom), 8'($urandom_range(0, 30)));
        3: load_config(8'd250, 8'd254, 8'd200, 8'd250, 8'd120, 8'd40);
        4: load_config(8'd70, 8'd22, 8'd0, 8'd0, 8'd255, 8'd255);
        default: load_config(8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // stall the result side long enough to back up the input
      if (p == 2) hold_req = 1'b1;
      stop_at = n_sent + ITEMS_PER_PHASE;
      while (n_sent < stop_at) random_item();
    end
    drain();

    if (board.faults == 0)
      $display("mouse_cursor_tracker_hit_test_unit verification clean");
    else
      $display("mouse_cursor_tracker_hit_test_unit verification failed");
    $finish;
  end

endmodule
